FILE: design/fwsm_pkg.sv
// ============================================================================
// Four-wheel steer mode mapper package
// Shared types, mode codes, register indexes and fixed-point helpers.
// ============================================================================
package fwsm_pkg;

    typedef logic [2:0] mode_t;

    // Steering modes.
    localparam mode_t MODE_FRONT         = 3'd0;
    localparam mode_t MODE_REAR          = 3'd1;
    localparam mode_t MODE_COUNTER       = 3'd2;
    localparam mode_t MODE_CRAB          = 3'd3;
    localparam mode_t MODE_PADDLE_CRAB   = 3'd4;
    localparam mode_t MODE_RANGE_COUNTER = 3'd5;
    localparam mode_t MODE_RANGE_CRAB    = 3'd6;
    localparam mode_t MODE_MOUSE         = 3'd7;

    // Item kinds.
    localparam logic OP_JOYSTICK = 1'b0;
    localparam logic OP_MOUSE    = 1'b1;

    // Configuration register indexes.
    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_AUTONOMOUS  = 2'd0;
    localparam reg_index_t REG_STEER_GAIN  = 2'd1;
    localparam reg_index_t REG_THRESHOLD   = 2'd2;
    localparam reg_index_t REG_RANGE_SCALE = 2'd3;

    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [14:0] GAIN_RESET      = 15'd2048;
    localparam logic [14:0] THRESHOLD_RESET = 15'd2048;
    localparam logic [15:0] SCALE_RESET     = 16'd4096;

    // Datapath widths.
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Rounding offsets for the Q1.15 and Q4.12 products.
    localparam logic signed [PROD_W-1:0] HALF_Q15 = 41'sd16384;
    localparam logic signed [PROD_W-1:0] HALF_Q12 = 41'sd2048;

    // Mouse path: rear = floor((4*p + 3*2^14) / (3*2^15)). The sum is first
    // shifted by 15, then biased positive and divided by three with a
    // reciprocal multiply that is exact for values below 2^21.
    localparam logic signed [PROD_W-1:0]  MOUSE_HALF  = 41'sd49152;
    localparam logic [18:0]               DIV3_BIAS   = 19'd196608;
    localparam logic signed [PROD_W-1:0]  DIV3_UNBIAS = 41'sd65536;
    localparam logic signed [MUL_B_W-1:0] RECIP3      = 21'sd699051;
    localparam int                        RECIP3_SHIFT = 21;

    typedef struct packed {
        logic take;
        logic mul1;
        logic mid;
        logic mul2;
        logic fin;
    } fwsm_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic emit;
        logic out_stall;
    } fwsm_status_t;

    function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [15:0] r;
        if (v > 41'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -41'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: design/fwsm_if.sv
// ============================================================================
// Four-wheel steer mode mapper channels
// Valid/ready channels for input items and result items.
// ============================================================================
interface fwsm_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] steer_axis;
    logic               mode_up;
    logic               mode_down;
    logic               right_paddle;
    logic               left_paddle;
    logic signed [15:0] mouse_turn;
    logic signed [15:0] mouse_blend;

    modport source (
        output valid, opcode, steer_axis, mode_up, mode_down,
               right_paddle, left_paddle, mouse_turn, mouse_blend,
        input  ready
    );
    modport sink (
        input  valid, opcode, steer_axis, mode_up, mode_down,
               right_paddle, left_paddle, mouse_turn, mouse_blend,
        output ready
    );
endinterface

interface fwsm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] front_angle;
    logic signed [15:0] rear_angle;
    logic [2:0]         current_mode;

    modport source (
        output valid, front_angle, rear_angle, current_mode,
        input  ready
    );
    modport sink (
        input  valid, front_angle, rear_angle, current_mode,
        output ready
    );
endinterface

FILE: design/fwsm_ctrl.sv
// ============================================================================
// Four-wheel steer mode mapper controller
// Sequences the two multiply passes of one transaction.
// ============================================================================
module fwsm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fwsm_pkg::fwsm_status_t status,
    output fwsm_pkg::fwsm_cmd_t    cmd
);
    import fwsm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MID,
        ST_MUL2,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.in_valid && status.emit)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MID;
            end
            ST_MID:
            begin
                cmd.mid    = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold the finished result until the output register is free.
                if (!status.out_stall)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/fwsm_dp.sv
// ============================================================================
// Four-wheel steer mode mapper datapath
// Configuration, mode register, shared multiplier and result register.
// ============================================================================
module fwsm_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  fwsm_pkg::reg_index_t           cfg_index,
    input  logic [fwsm_pkg::CFG_DATA_W-1:0] cfg_data,
    fwsm_in_if.sink                        in_chan,
    fwsm_out_if.source                     out_chan,
    input  fwsm_pkg::fwsm_cmd_t            cmd,
    output fwsm_pkg::fwsm_status_t         status
);
    import fwsm_pkg::*;

    // Configuration registers.
    logic        auto_reg;
    logic [14:0] gain_reg;
    logic [14:0] thresh_reg;
    logic [15:0] scale_reg;

    // Mode and captured transaction.
    mode_t              mode_reg;
    mode_t              mode_next;
    logic               op_reg;
    logic signed [15:0] axis_reg;
    logic signed [15:0] turn_reg;
    logic signed [15:0] blend_reg;
    logic               left_reg;
    logic               right_reg;

    // Arithmetic pipeline registers.
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [15:0]       angle_reg;
    logic signed [16:0]       diff_reg;
    logic [18:0]              z_reg;

    // Result register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] front_reg;
    logic signed [15:0] rear_reg;
    mode_t              out_mode_reg;

    logic accept;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic signed [PROD_W-1:0] joy_sum;
    logic signed [PROD_W-1:0] joy_shift;
    logic signed [15:0]       angle;
    logic signed [16:0]       angle_x;
    logic signed [16:0]       thresh_x;
    logic signed [16:0]       diff;
    logic signed [PROD_W-1:0] mouse_sum;
    logic signed [PROD_W-1:0] mouse_shift;
    logic [18:0]              z_val;

    logic signed [PROD_W-1:0] angle_w;
    logic signed [15:0]       range_val;
    logic signed [PROD_W-1:0] range_w;
    logic signed [PROD_W-1:0] mouse_q;
    logic signed [15:0]       front_val;
    logic signed [15:0]       rear_val;

    // ------------------------------------------------------------------
    // Handshake and mode step
    // ------------------------------------------------------------------
    assign in_chan.ready = cmd.take;
    assign accept        = cmd.take && in_chan.valid;

    always_comb
    begin
        mode_next = mode_reg;
        if (in_chan.opcode == OP_JOYSTICK)
        begin
            if (in_chan.mode_up)
            begin
                mode_next = mode_reg + 3'd1;
            end
            else if (in_chan.mode_down)
            begin
                mode_next = mode_reg - 3'd1;
            end
        end
    end

    assign status.in_valid  = in_chan.valid;
    assign status.emit      = !auto_reg && ((in_chan.opcode == OP_MOUSE)
                                            ? (mode_reg == MODE_MOUSE)
                                            : (mode_next != MODE_MOUSE));
    assign status.out_stall = out_valid_reg && !out_chan.ready;

    // ------------------------------------------------------------------
    // Configuration and mode state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg   <= 1'b0;
            gain_reg   <= GAIN_RESET;
            thresh_reg <= THRESHOLD_RESET;
            scale_reg  <= SCALE_RESET;
            mode_reg   <= MODE_FRONT;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AUTONOMOUS:  auto_reg   <= cfg_data[0];
                    REG_STEER_GAIN:  gain_reg   <= cfg_data[14:0];
                    REG_THRESHOLD:   thresh_reg <= cfg_data[14:0];
                    REG_RANGE_SCALE: scale_reg  <= cfg_data;
                    default:         auto_reg   <= auto_reg;
                endcase
            end
            if (accept && !auto_reg)
            begin
                mode_reg <= mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_chan.opcode;
            axis_reg  <= in_chan.steer_axis;
            turn_reg  <= in_chan.mouse_turn;
            blend_reg <= in_chan.mouse_blend;
            left_reg  <= in_chan.left_paddle;
            right_reg <= in_chan.right_paddle;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    always_comb
    begin
        if (cmd.mul2)
        begin
            if (op_reg == OP_MOUSE)
            begin
                mul_a = {1'b0, z_reg};
                mul_b = RECIP3;
            end
            else
            begin
                mul_a = {{3{diff_reg[16]}}, diff_reg};
                mul_b = {5'b0, scale_reg};
            end
        end
        else
        begin
            if (op_reg == OP_MOUSE)
            begin
                mul_a = {{4{turn_reg[15]}}, turn_reg};
                mul_b = {{5{blend_reg[15]}}, blend_reg};
            end
            else
            begin
                mul_a = {5'b0, gain_reg};
                mul_b = {{5{axis_reg[15]}}, axis_reg};
            end
        end
    end

    assign prod = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Middle step: scaled angle and threshold excess, or mouse quotient prep
    // ------------------------------------------------------------------
    assign joy_sum   = prod_reg + HALF_Q15;
    assign joy_shift = joy_sum >>> 15;
    assign angle     = joy_shift[15:0];
    assign angle_x   = {angle[15], angle};
    assign thresh_x  = {2'b00, thresh_reg};

    always_comb
    begin
        if (angle_x > thresh_x)
        begin
            diff = angle_x - thresh_x;
        end
        else if (angle_x < -thresh_x)
        begin
            diff = angle_x + thresh_x;
        end
        else
        begin
            diff = '0;
        end
    end

    assign mouse_sum   = (prod_reg <<< 2) + MOUSE_HALF;
    assign mouse_shift = mouse_sum >>> 15;
    assign z_val       = mouse_shift[18:0] + DIV3_BIAS;

    always_ff @(posedge clk)
    begin
        if (cmd.mul1 || cmd.mul2)
        begin
            prod_reg <= prod;
        end
        if (cmd.mid)
        begin
            angle_reg <= angle;
            diff_reg  <= diff;
            z_reg     <= z_val;
        end
    end

    // ------------------------------------------------------------------
    // Final step: select front and rear angles
    // ------------------------------------------------------------------
    assign angle_w   = {{(PROD_W-16){angle_reg[15]}}, angle_reg};
    assign range_val = sat16((prod_reg + HALF_Q12) >>> 12);
    assign range_w   = {{(PROD_W-16){range_val[15]}}, range_val};
    assign mouse_q   = (prod_reg >>> RECIP3_SHIFT) - DIV3_UNBIAS;

    always_comb
    begin
        front_val = angle_reg;
        rear_val  = '0;
        if (op_reg == OP_MOUSE)
        begin
            front_val = turn_reg;
            rear_val  = sat16(mouse_q);
        end
        else
        begin
            case (mode_reg)
                MODE_FRONT:         rear_val = '0;
                MODE_REAR:
                begin
                    front_val = '0;
                    rear_val  = angle_reg;
                end
                MODE_COUNTER:       rear_val = sat16(-angle_w);
                MODE_CRAB:          rear_val = angle_reg;
                MODE_PADDLE_CRAB:
                begin
                    if ((left_reg && angle_reg > 16'sd0) ||
                        (right_reg && angle_reg < 16'sd0))
                    begin
                        rear_val = angle_reg;
                    end
                end
                MODE_RANGE_COUNTER: rear_val = sat16(-range_w);
                MODE_RANGE_CRAB:    rear_val = range_val;
                default:
                begin
                    front_val = '0;
                    rear_val  = '0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            front_reg    <= front_val;
            rear_reg     <= rear_val;
            out_mode_reg <= mode_reg;
        end
    end

    assign out_chan.valid        = out_valid_reg;
    assign out_chan.front_angle  = front_reg;
    assign out_chan.rear_angle   = rear_reg;
    assign out_chan.current_mode = out_mode_reg;

endmodule

FILE: design/four_wheel_steer_mode_mapper_top.sv
// ============================================================================
// Four-wheel steer mode mapper
// Maps joystick and 3D-mouse transactions to front and rear wheel angles.
// ============================================================================
// The block holds a steering mode from 0 to 7 and turns each accepted input
// transaction into at most one result transaction carrying the front angle,
// the rear angle (both signed Q3.12, saturated) and the mode after the item.
// A result-giving transaction is accepted in idle and steps through MUL1,
// MID, MUL2 and FIN, where the result is written to the output register
// once any earlier result there is taken; only then is the block idle and
// ready again. The steps follow the single shared multiplier, used twice per
// item (gain times axis, then excess times scale, or turn times blend, then
// a reciprocal multiply for the division by three). A transaction that gives
// no result (autonomous mode, a mouse item outside mode 7, or a joystick item
// that lands in mode 7) is consumed in its acceptance cycle and the block is
// ready again on the next cycle. A finished result waits in the output
// register while the next input is already accepted and worked on; only the
// write of the following result waits for the output to drain. Configuration
// writes take effect at the clock edge that sees cfg_we high and should be
// made only while no transaction is in flight.
// ============================================================================
module four_wheel_steer_mode_mapper_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  fwsm_pkg::reg_index_t            cfg_index,
    input  logic [fwsm_pkg::CFG_DATA_W-1:0] cfg_data,
    fwsm_in_if.sink                         in_chan,
    fwsm_out_if.source                      out_chan
);
    import fwsm_pkg::*;

    // Commands from the controller and status back from the datapath.
    fwsm_cmd_t    cmd;
    fwsm_status_t status;

    // The controller steps through the two multiply passes of an item.
    fwsm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath holds the configuration, the mode, the arithmetic and
    // the output register, and drives both channel handshakes.
    fwsm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_chan   (in_chan),
        .out_chan  (out_chan),
        .cmd       (cmd),
        .status    (status)
    );

    // A result becomes valid only through the final write of the sequence.
    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_chan.valid) |-> $past(cmd.fin))
        else $error("result valid rose without a final write");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin && out_chan.valid) |-> out_chan.ready)
        else $error("pending result overwritten");

    // An item that gives no result leaves the block ready on the next cycle.
    a_drop_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_chan.valid && in_chan.ready && !status.emit) |=> in_chan.ready)
        else $error("block not ready after an item without result");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Four-wheel steer mode mapper testbench
// Drives joystick and 3D-mouse transactions, checks wheel angles and mode.
// ============================================================================
// A short directed table comes first. It walks every steering mode, both
// wraps of the mode counter, the paddle gating, the mouse path and autonomous
// suppression. Rows whose result is obvious carry it typed in. The remaining
// rows, and the random phases after them, are checked against a predictor
// that runs inside this module. Each phase rewrites all four registers while
// the block is idle. The phases include both extremes of every register.
// ============================================================================
module testbench;
    import fwsm_pkg::*;

    // One input transaction, laid out like the fields of the input channel.
    typedef struct packed {
        logic               opcode;
        logic signed [15:0] steer_axis;
        logic               mode_up;
        logic               mode_down;
        logic               right_paddle;
        logic               left_paddle;
        logic signed [15:0] mouse_turn;
        logic signed [15:0] mouse_blend;
    } steer_cmd_t;

    // One result transaction.
    typedef struct packed {
        logic signed [15:0] front_angle;
        logic signed [15:0] rear_angle;
        mode_t              current_mode;
    } wheel_angles_t;

    // A directed row either writes a register or sends a command. The
    // command's result is either typed in, taken from the predictor, or
    // known to be absent.
    typedef enum logic [1:0] {STEP_CMD, STEP_REG} step_kind_t;
    typedef enum logic [1:0] {CHECK_MODEL, CHECK_TYPED, CHECK_SILENT} check_kind_t;

    typedef struct packed {
        step_kind_t    kind;
        check_kind_t   check;
        reg_index_t    reg_index;
        logic [15:0]   reg_data;
        steer_cmd_t    cmd;
        wheel_angles_t typed;
    } plan_step_t;

    localparam logic signed [15:0] AXIS_MAX      = 16'sh7FFF;
    localparam logic signed [15:0] AXIS_MIN      = 16'sh8000;
    localparam logic signed [15:0] AXIS_HALF     = 16'sh4000;
    localparam logic signed [15:0] AXIS_NEG_HALF = 16'shC000;
    localparam logic signed [15:0] ZERO16        = 16'sh0000;

    // No-result transactions are consumed on acceptance and owed results are
    // awaited first, so this many idle cycles is ample before a register write.
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;

    // Directed table, run right after reset with the reset register values
    // (gain 2048, threshold 2048, scale 4096). With gain 2048 a half axis
    // gives an angle of exactly 1024 and a full axis gives 2048.
    localparam plan_step_t DIRECTED_PLAN [27] = '{
        // Mode 0 at both ends of the axis.
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_MAX, 1'b0, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16},
          '{16'sd2048, ZERO16, MODE_FRONT}},
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_MIN, 1'b0, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16},
          '{-16'sd2048, ZERO16, MODE_FRONT}},
        // Step up through rear-only, counter and crab steering. The second
        // row presses both buttons, and up must win.
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, ZERO16, 1'b1, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16},
          '{ZERO16, ZERO16, MODE_REAR}},
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_HALF, 1'b1, 1'b1, 1'b0, 1'b0, ZERO16, ZERO16},
          '{16'sd1024, -16'sd1024, MODE_COUNTER}},
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_NEG_HALF, 1'b1, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16},
          '{-16'sd1024, -16'sd1024, MODE_CRAB}},
        // Paddle crab: only the paddle on the side of the turn engages it.
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_HALF, 1'b1, 1'b0, 1'b0, 1'b1, ZERO16, ZERO16},
          '{16'sd1024, 16'sd1024, MODE_PADDLE_CRAB}},
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_NEG_HALF, 1'b0, 1'b0, 1'b1, 1'b0, ZERO16, ZERO16},
          '{-16'sd1024, -16'sd1024, MODE_PADDLE_CRAB}},
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_HALF, 1'b0, 1'b0, 1'b1, 1'b0, ZERO16, ZERO16},
          '{16'sd1024, ZERO16, MODE_PADDLE_CRAB}},
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_NEG_HALF, 1'b0, 1'b0, 1'b0, 1'b1, ZERO16, ZERO16},
          '{-16'sd1024, ZERO16, MODE_PADDLE_CRAB}},
        // Range counter with the angle sitting exactly on the threshold.
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_MAX, 1'b1, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16},
          '{16'sd2048, ZERO16, MODE_RANGE_COUNTER}},
        // Full gain, then full scale, so that the range modes saturate.
        '{STEP_REG, CHECK_SILENT, REG_STEER_GAIN, 16'd32767, '0, '0},
        '{STEP_CMD, CHECK_MODEL, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_MAX, 1'b0, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16}, '0},
        '{STEP_CMD, CHECK_MODEL, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_MIN, 1'b0, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16}, '0},
        '{STEP_REG, CHECK_SILENT, REG_RANGE_SCALE, 16'd65535, '0, '0},
        '{STEP_CMD, CHECK_MODEL, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_MIN, 1'b1, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16}, '0},
        '{STEP_CMD, CHECK_MODEL, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, 16'sd20000, 1'b0, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16}, '0},
        // A joystick transaction that lands in mouse mode gives no result.
        '{STEP_CMD, CHECK_SILENT, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, 16'sd1234, 1'b1, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16}, '0},
        // Mouse extremes: the rear product overflows and saturates.
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_MOUSE, ZERO16, 1'b0, 1'b0, 1'b0, 1'b0, AXIS_MIN, AXIS_MIN},
          '{AXIS_MIN, AXIS_MAX, MODE_MOUSE}},
        '{STEP_CMD, CHECK_MODEL, REG_AUTONOMOUS, 16'd0,
          '{OP_MOUSE, ZERO16, 1'b0, 1'b0, 1'b0, 1'b0, AXIS_MAX, AXIS_MIN}, '0},
        // Wrap upward from 7 to 0, then a mouse transaction outside mode 7,
        // then a wrap downward from 0 to 7.
        '{STEP_CMD, CHECK_MODEL, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, 16'sd100, 1'b1, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16}, '0},
        '{STEP_CMD, CHECK_SILENT, REG_AUTONOMOUS, 16'd0,
          '{OP_MOUSE, ZERO16, 1'b0, 1'b0, 1'b0, 1'b0, AXIS_MAX, AXIS_MAX}, '0},
        '{STEP_CMD, CHECK_SILENT, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, ZERO16, 1'b0, 1'b1, 1'b0, 1'b0, ZERO16, ZERO16}, '0},
        // Autonomous mode swallows both kinds and leaves the mode alone.
        '{STEP_REG, CHECK_SILENT, REG_AUTONOMOUS, 16'd1, '0, '0},
        '{STEP_CMD, CHECK_SILENT, REG_AUTONOMOUS, 16'd0,
          '{OP_JOYSTICK, AXIS_MAX, 1'b1, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16}, '0},
        '{STEP_CMD, CHECK_SILENT, REG_AUTONOMOUS, 16'd0,
          '{OP_MOUSE, ZERO16, 1'b0, 1'b0, 1'b0, 1'b0, 16'sd4096, 16'sd4096}, '0},
        '{STEP_REG, CHECK_SILENT, REG_AUTONOMOUS, 16'd0, '0, '0},
        '{STEP_CMD, CHECK_TYPED, REG_AUTONOMOUS, 16'd0,
          '{OP_MOUSE, ZERO16, 1'b0, 1'b0, 1'b0, 1'b0, ZERO16, ZERO16},
          '{ZERO16, ZERO16, MODE_MOUSE}}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    reg_index_t        cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fwsm_in_if  in_chan ();
    fwsm_out_if out_chan ();

    four_wheel_steer_mode_mapper_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_chan   (in_chan),
        .out_chan  (out_chan)
    );

    // Predictor state: the steering mode and a shadow of every register.
    mode_t       steer_mode_p  = MODE_FRONT;
    logic        autonomous_p  = 1'b0;
    logic [14:0] gain_p        = GAIN_RESET;
    logic [14:0] threshold_p   = THRESHOLD_RESET;
    logic [15:0] scale_p       = SCALE_RESET;

    // Wheel angles still owed by the block, oldest first.
    wheel_angles_t pending_angles [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  gaps_on        = 1'b1;
    bit  stalls_on      = 1'b1;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic logic signed [15:0] clamp_q312(input longint v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Divides by 2^k and rounds to nearest, with halves going up.
    function automatic longint round_shift(input longint x, input int k);
        return (x + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    // Rear angle of the range modes before any negation: zero inside the
    // dead band, otherwise the excess over the band times the Q4.12 scale.
    function automatic longint range_rear(input longint a);
        longint t;
        t = longint'(threshold_p);
        if (a > t)
        begin
            return clamp_q312(round_shift((a - t) * longint'(scale_p), 12));
        end
        if (a < -t)
        begin
            return clamp_q312(round_shift((a + t) * longint'(scale_p), 12));
        end
        return 0;
    endfunction

    // Applies one accepted command to the predicted mode. It returns 1 and
    // the wheel angles when the command must give a result.
    function automatic bit predict_wheel_angles(input steer_cmd_t cmd,
                                                output wheel_angles_t res);
        longint a;
        longint p;
        longint q;
        res = '0;
        if (autonomous_p)
        begin
            return 1'b0;
        end
        if (cmd.opcode == OP_MOUSE)
        begin
            if (steer_mode_p != MODE_MOUSE)
            begin
                return 1'b0;
            end
            // rear = round(turn * blend * 4 / (3 * 2^15)), halves up, using
            // a floor division that is correct for negative numerators.
            p = longint'($signed(cmd.mouse_turn)) * longint'($signed(cmd.mouse_blend)) * 4
                + 49152;
            q = (p >= 0) ? p / 98304 : -((-p + 98303) / 98304);
            res.front_angle  = cmd.mouse_turn;
            res.rear_angle   = clamp_q312(q);
            res.current_mode = steer_mode_p;
            return 1'b1;
        end

        if (cmd.mode_up)
        begin
            steer_mode_p = steer_mode_p + 3'd1;
        end
        else if (cmd.mode_down)
        begin
            steer_mode_p = steer_mode_p - 3'd1;
        end

        a = clamp_q312(round_shift(longint'(gain_p) * longint'($signed(cmd.steer_axis)), 15));
        res.front_angle  = clamp_q312(a);
        res.current_mode = steer_mode_p;
        case (steer_mode_p)
            MODE_FRONT:
            begin
                res.rear_angle = '0;
            end
            MODE_REAR:
            begin
                res.front_angle = '0;
                res.rear_angle  = clamp_q312(a);
            end
            MODE_COUNTER:
            begin
                res.rear_angle = clamp_q312(-a);
            end
            MODE_CRAB:
            begin
                res.rear_angle = clamp_q312(a);
            end
            MODE_PADDLE_CRAB:
            begin
                if ((cmd.left_paddle && a > 0) || (cmd.right_paddle && a < 0))
                begin
                    res.rear_angle = clamp_q312(a);
                end
                else
                begin
                    res.rear_angle = '0;
                end
            end
            MODE_RANGE_COUNTER:
            begin
                res.rear_angle = clamp_q312(-range_rear(a));
            end
            MODE_RANGE_CRAB:
            begin
                res.rear_angle = clamp_q312(range_rear(a));
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // A full-range word, with the corners of the range picked often.
    function automatic logic signed [15:0] random_word();
        logic signed [15:0] w;
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 4))
                0:       w = AXIS_MAX;
                1:       w = AXIS_MIN;
                2:       w = 16'sd1;
                3:       w = -16'sd1;
                default: w = ZERO16;
            endcase
        end
        else
        begin
            w = 16'($urandom);
        end
        return w;
    endfunction

    // Mouse transactions only do work in mode 7, so they are favored there
    // and kept rare elsewhere. Fields that the chosen kind ignores are still
    // randomized so that every input bit toggles.
    function automatic steer_cmd_t random_steer_cmd();
        steer_cmd_t cmd;
        if (steer_mode_p == MODE_MOUSE)
        begin
            cmd.opcode = ($urandom_range(0, 9) < 7) ? OP_MOUSE : OP_JOYSTICK;
        end
        else
        begin
            cmd.opcode = ($urandom_range(0, 9) < 2) ? OP_MOUSE : OP_JOYSTICK;
        end
        cmd.steer_axis   = random_word();
        cmd.mode_up      = ($urandom_range(0, 3) == 0);
        cmd.mode_down    = ($urandom_range(0, 4) == 0);
        cmd.right_paddle = 1'($urandom_range(0, 1));
        cmd.left_paddle  = 1'($urandom_range(0, 1));
        cmd.mouse_turn   = random_word();
        cmd.mouse_blend  = random_word();
        return cmd;
    endfunction

    // Sends one command. The task is entered just after a falling edge and
    // returns just after one, leaving valid high so that back-to-back
    // transactions need no dead cycle. The expectation is recorded at the
    // rising edge that completes the handshake.
    task automatic send_cmd(input steer_cmd_t cmd, input check_kind_t check,
                            input wheel_angles_t typed);
        wheel_angles_t predicted;
        bit            gives_result;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_chan.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_chan.opcode       = cmd.opcode;
        in_chan.steer_axis   = cmd.steer_axis;
        in_chan.mode_up      = cmd.mode_up;
        in_chan.mode_down    = cmd.mode_down;
        in_chan.right_paddle = cmd.right_paddle;
        in_chan.left_paddle  = cmd.left_paddle;
        in_chan.mouse_turn   = cmd.mouse_turn;
        in_chan.mouse_blend  = cmd.mouse_blend;
        in_chan.valid        = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_chan.ready);

        // The predictor runs on every row so that its mode stays in step,
        // even where the row supplies its own expectation.
        gives_result = predict_wheel_angles(cmd, predicted);
        if (check == CHECK_TYPED)
        begin
            pending_angles.push_back(typed);
        end
        else if (check == CHECK_MODEL && gives_result)
        begin
            pending_angles.push_back(predicted);
        end
        @(negedge clk);
    endtask

    // Register writes happen only with the block idle: input stopped, every
    // owed result delivered, and a further DRAIN_CYCLES of margin after that.
    task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
        in_chan.valid = 1'b0;
        while (pending_angles.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            REG_AUTONOMOUS:  autonomous_p = data[0];
            REG_STEER_GAIN:  gain_p       = data[14:0];
            REG_THRESHOLD:   threshold_p  = data[14:0];
            REG_RANGE_SCALE: scale_p      = data;
            default:         ;
        endcase
    endtask

    // One random phase: all four registers rewritten, then a run of random
    // commands, with or without idling on both channels.
    task automatic run_phase(input int count, input bit autonomous,
                             input int gain, input int threshold, input int scale,
                             input bit idling);
        write_reg(REG_AUTONOMOUS, 16'(autonomous));
        write_reg(REG_STEER_GAIN, 16'(gain));
        write_reg(REG_THRESHOLD, 16'(threshold));
        write_reg(REG_RANGE_SCALE, 16'(scale));
        gaps_on   = idling;
        stalls_on = idling;
        repeat (count)
        begin
            send_cmd(random_steer_cmd(), CHECK_MODEL, '0);
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_AUTONOMOUS;
        cfg_data             = '0;
        in_chan.valid        = 1'b0;
        in_chan.opcode       = OP_JOYSTICK;
        in_chan.steer_axis   = '0;
        in_chan.mode_up      = 1'b0;
        in_chan.mode_down    = 1'b0;
        in_chan.right_paddle = 1'b0;
        in_chan.left_paddle  = 1'b0;
        in_chan.mouse_turn   = '0;
        in_chan.mouse_blend  = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table.
        for (int i = 0; i < $size(DIRECTED_PLAN); i++)
        begin
            if (DIRECTED_PLAN[i].kind == STEP_REG)
            begin
                write_reg(DIRECTED_PLAN[i].reg_index, DIRECTED_PLAN[i].reg_data);
            end
            else
            begin
                send_cmd(DIRECTED_PLAN[i].cmd, DIRECTED_PLAN[i].check,
                         DIRECTED_PLAN[i].typed);
            end
        end

        // Random phases. Two at register extremes come first, then random settings
        // and a third extreme phase; the last two keep the threshold small so the
        // range modes engage often. The autonomous phase only checks that nothing
        // comes out. The final phase runs with no idling at all.
        run_phase(80, 1'b0, 32767, 0, 65535, 1'b1);
        run_phase(80, 1'b0, 0, 32767, 0, 1'b1);
        run_phase(80, 1'b0, $urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 65535), 1'b0);
        run_phase(20, 1'b1, $urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 65535), 1'b1);
        run_phase(80, 1'b0, 32767, 32767, 65535, 1'b1);
        run_phase(80, 1'b0, $urandom_range(4096, 32767), $urandom_range(0, 4096),
                  $urandom_range(0, 65535), 1'b1);
        run_phase(100, 1'b0, $urandom_range(0, 32767), $urandom_range(0, 8192),
                  $urandom_range(0, 65535), 1'b0);

        // Let the last results drain, then leave room for anything stray.
        in_chan.valid = 1'b0;
        while (pending_angles.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Back-pressure: ready drops for bursts of random length while stalls are
    // enabled, and stays high otherwise.
    initial
    begin
        out_chan.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                out_chan.ready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            out_chan.ready = 1'b1;
        end
    end

    // Every result transaction is matched against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        wheel_angles_t want;
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("result with no transaction pending: front %0d rear %0d mode %0d",
                       out_chan.front_angle, out_chan.rear_angle, out_chan.current_mode);
                mismatch_count++;
            end
            else
            begin
                want = pending_angles.pop_front();
                if (out_chan.front_angle !== want.front_angle)
                begin
                    $error("front_angle: expected %0d, actual %0d",
                           want.front_angle, out_chan.front_angle);
                    mismatch_count++;
                end
                if (out_chan.rear_angle !== want.rear_angle)
                begin
                    $error("rear_angle: expected %0d, actual %0d",
                           want.rear_angle, out_chan.rear_angle);
                    mismatch_count++;
                end
                if (out_chan.current_mode !== want.current_mode)
                begin
                    $error("current_mode: expected %0d, actual %0d",
                           want.current_mode, out_chan.current_mode);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog. A run that hangs is stopped and reported as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

FILE: files.f
design/fwsm_pkg.sv
design/fwsm_if.sv
design/fwsm_ctrl.sv
design/fwsm_dp.sv
design/four_wheel_steer_mode_mapper_top.sv
verif/testbench.sv
